### rtl/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// Frame count, field widths, cell commands and the controller state type.
// ---------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int FRAME_COUNT  = 4;
  localparam int TAG_W        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int ADDR_W       = 32;
  localparam int PAGE_SHIFT   = 12;
  localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
  localparam int SHOWN_FRAMES = 4;
  localparam int USED_W       = 2;

  // Command broadcast to every cell of the ring.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_HIT,
    OP_PASS,
    OP_PLACE
  } cell_op_e;

  // Contents of one frame as it travels around the ring.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              valid;
    logic              used;
    logic [TAG_W-1:0]  tag;
  } cell_state_t;

  // Ring status seen by the controller.
  typedef struct packed {
    logic any_match;
    logic head_used;
  } ring_stat_t;

  // Controller outputs to the datapath.
  typedef struct packed {
    logic     take_in;
    cell_op_e op;
    logic     cap_hit;
    logic     cap_place;
    logic     emit;
  } cpr_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_SWEEP,
    ST_EMIT
  } ctrl_state_e;

endpackage

`default_nettype wire

### rtl/clock_page_replacement.sv
// ---------------------------------------------------------------------------
// clock_page_replacement: second-chance page replacement over a frame ring
// Looks up the page of each address, places it by the clock sweep on a
// miss, and reports the frame used together with all frame contents.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one virtual address per beat (in_valid_i,
// in_stall_o); the output channel returns exactly one result beat per
// input beat (out_valid_o, out_stall_i), in order.
// The frames sit in a ring of cells. The clock hand is always the cell at
// the head of the ring: advancing the hand rotates every frame one cell.
// After taking an address, the block does one parallel compare; on a miss
// it then rotates the ring, clearing each set use bit at the head (at
// most FRAME_COUNT frames are passed with all use bits set) until a clear
// one takes the page; then it loads the output register. The block works
// on one address at a time: it takes no new address until the last one
// has been loaded into the output register.
// Reset empties every frame, clears all use bits and points the hand at
// frame zero; no output beat is pending after reset.
// While the receiver stalls, the finished beat holds in the output
// register and the next address is still taken; that address is worked
// on and then waits for the output register to free.
// ---------------------------------------------------------------------------
`default_nettype none

module clock_page_replacement (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [cpr_pkg::ADDR_W-1:0]  virtual_address_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic                        hit_o,
  output logic [cpr_pkg::USED_W-1:0]  frame_used_o,
  output logic [cpr_pkg::PAGE_W-1:0]  frame0_page_o,
  output logic [cpr_pkg::PAGE_W-1:0]  frame1_page_o,
  output logic [cpr_pkg::PAGE_W-1:0]  frame2_page_o,
  output logic [cpr_pkg::PAGE_W-1:0]  frame3_page_o,
  output logic [cpr_pkg::SHOWN_FRAMES-1:0] frames_valid_o
);
  import cpr_pkg::*;

  cpr_ctl_t    ctl;
  ring_stat_t  stat;
  logic        out_free;

  // Page number of the address in flight.
  logic [PAGE_W-1:0] page_q;

  cell_state_t            cell_st  [FRAME_COUNT];
  cell_state_t            cell_mod [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] cell_match;
  logic [TAG_W-1:0]       match_tag;

  // Outcome of the lookup, held until the output register is free.
  logic             hit_q;
  logic [TAG_W-1:0] used_q;

  // Output register.
  logic                    out_valid_q;
  logic                    out_hit_q;
  logic [USED_W-1:0]       out_used_q;
  logic [PAGE_W-1:0]       out_page_q [SHOWN_FRAMES];
  logic [SHOWN_FRAMES-1:0] out_fv_q;
  logic [PAGE_W-1:0]       shown_page [SHOWN_FRAMES];
  logic [SHOWN_FRAMES-1:0] shown_fv;

  assign out_free = !out_valid_q || !out_stall_i;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.take_in) page_q <= virtual_address_i[ADDR_W-1:PAGE_SHIFT];
  end

  // The ring: cell 0 is the clock hand, and each cell loads from the cell
  // after it when the ring rotates, so the head moves on to the next frame.
  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    localparam int Nxt = (i + 1) % FRAME_COUNT;
    cpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .head_i     (i == 0),
      .init_tag_i (TAG_W'(i)),
      .op_i       (ctl.op),
      .page_i     (page_q),
      .nbr_i      (cell_mod[Nxt]),
      .mod_o      (cell_mod[i]),
      .state_o    (cell_st[i]),
      .match_o    (cell_match[i])
    );
  end

  // At most one valid cell holds a given page, so an OR of tags suffices.
  always_comb begin
    match_tag = '0;
    for (int c = 0; c < FRAME_COUNT; c++) begin
      if (cell_match[c]) match_tag = match_tag | cell_st[c].tag;
    end
  end

  assign stat.any_match = |cell_match;
  assign stat.head_used = cell_st[0].used;

  always_ff @(posedge clk_i) begin
    if (ctl.cap_hit) begin
      hit_q  <= 1'b1;
      used_q <= match_tag;
    end else if (ctl.cap_place) begin
      hit_q  <= 1'b0;
      used_q <= cell_st[0].tag;
    end
  end

  // Sort the rotated ring back into frame order for the result.
  always_comb begin
    for (int k = 0; k < SHOWN_FRAMES; k++) begin
      shown_page[k] = '0;
      shown_fv[k]   = 1'b0;
      for (int c = 0; c < FRAME_COUNT; c++) begin
        if (int'(cell_st[c].tag) == k && cell_st[c].valid) begin
          shown_page[k] = shown_page[k] | cell_st[c].page;
          shown_fv[k]   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_hit_q  <= hit_q;
      out_used_q <= USED_W'(used_q);
      out_page_q <= shown_page;
      out_fv_q   <= shown_fv;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign frame_used_o   = out_used_q;
  assign frame0_page_o  = out_page_q[0];
  assign frame1_page_o  = out_page_q[1];
  assign frame2_page_o  = out_page_q[2];
  assign frame3_page_o  = out_page_q[3];
  assign frames_valid_o = out_fv_q;

endmodule

`default_nettype wire

### rtl/cpr_cell.sv
// ---------------------------------------------------------------------------
// cpr_cell: one frame slot of the rotating clock ring
// Holds a page, valid and use bit plus the frame index, and hands its
// contents to the neighbor whenever the ring rotates.
// ---------------------------------------------------------------------------
`default_nettype none

module cpr_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          head_i,
  input  wire  [cpr_pkg::TAG_W-1:0]    init_tag_i,
  input  wire  cpr_pkg::cell_op_e      op_i,
  input  wire  [cpr_pkg::PAGE_W-1:0]   page_i,
  input  wire  cpr_pkg::cell_state_t   nbr_i,
  output cpr_pkg::cell_state_t         mod_o,
  output cpr_pkg::cell_state_t         state_o,
  output logic                         match_o
);
  import cpr_pkg::*;

  cell_state_t state_q, state_d, mod;
  logic        rotate;

  assign match_o = state_q.valid && (state_q.page == page_i);
  assign rotate  = (op_i == OP_PASS) || (op_i == OP_PLACE);

  always_comb begin
    mod = state_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_HIT: begin
        if (match_o) mod.used = 1'b1;
      end
      OP_PASS: begin
        if (head_i) mod.used = 1'b0;
      end
      OP_PLACE: begin
        if (head_i) begin
          mod.page  = page_i;
          mod.valid = 1'b1;
          mod.used  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    state_d = rotate ? nbr_i : mod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{page: '0, valid: 1'b0, used: 1'b0, tag: init_tag_i};
    end else begin
      state_q <= state_d;
    end
  end

  assign mod_o   = mod;
  assign state_o = state_q;

endmodule

`default_nettype wire

### rtl/cpr_ctrl.sv
// ---------------------------------------------------------------------------
// cpr_ctrl: sequencer for lookup, sweep and result hand-off
// Compares once, then on a miss rotates the ring until the head has a clear use bit.
// ---------------------------------------------------------------------------
`default_nettype none

module cpr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  out_free_i,
  input  wire cpr_pkg::ring_stat_t stat_i,
  output logic                 in_stall_o,
  output cpr_pkg::cpr_ctl_t    ctl_o
);
  import cpr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '{take_in: 1'b0, op: OP_HOLD, cap_hit: 1'b0, cap_place: 1'b0,
                   emit: 1'b0};
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.take_in = 1'b1;
          state_d       = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (stat_i.any_match) begin
          ctl_o.op      = OP_HIT;
          ctl_o.cap_hit = 1'b1;
          state_d       = ST_EMIT;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // A set use bit at the head is cleared and passed; a clear one takes the page.
        if (stat_i.head_used) begin
          ctl_o.op = OP_PASS;
        end else begin
          ctl_o.op        = OP_PLACE;
          ctl_o.cap_place = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          ctl_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/cpr_checker.sv
// ---------------------------------------------------------------------------
// cpr_checker: port-level checks for the clock page replacement block
// Watches the top-level ports only and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cpr_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_stall_o,
  input wire [cpr_pkg::ADDR_W-1:0]         virtual_address_i,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire                               hit_o,
  input wire [cpr_pkg::USED_W-1:0]         frame_used_o,
  input wire [cpr_pkg::PAGE_W-1:0]         frame0_page_o,
  input wire [cpr_pkg::PAGE_W-1:0]         frame1_page_o,
  input wire [cpr_pkg::PAGE_W-1:0]         frame2_page_o,
  input wire [cpr_pkg::PAGE_W-1:0]         frame3_page_o,
  input wire [cpr_pkg::SHOWN_FRAMES-1:0]   frames_valid_o
);
  import cpr_pkg::*;

  // A stalled result beat keeps its hit flag, used frame, valid mask and frame 0 page.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) &&
    $stable(frame_used_o) && $stable(frames_valid_o) && $stable(frame0_page_o))
    else $error("stalled result beat changed");

  // The frame reported as used always holds a valid page.
  a_used_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frames_valid_o[frame_used_o])
    else $error("reported frame is not valid");

  // One address at a time: the input stalls right after a beat is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // Frames only fill up: a result never shows fewer valid frames than before.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o ||
    ((frames_valid_o & $past(frames_valid_o)) == $past(frames_valid_o)))
    else $error("a valid frame was lost");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);

`default_nettype wire
